// ----- hw/rtl/signed_decimal_add_sub_mul_assert.svh -----
// Assertion macros for the signed decimal arithmetic unit.
// Used by the top level; needs no package.
`ifndef SIGNED_DECIMAL_ADD_SUB_MUL_ASSERT_SVH
`define SIGNED_DECIMAL_ADD_SUB_MUL_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked at each rising edge outside reset
`define SDASM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdasm assertion failed");
// Next-cycle implication, checked at each rising edge outside reset
`define SDASM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdasm assertion failed");
`else
`define SDASM_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SDASM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/sdasm_pkg.sv -----
// Shared types, constants and helpers of the signed decimal arithmetic unit.
// No dependencies; used by sdasm_digit_alu and signed_decimal_add_sub_mul.
package sdasm_pkg;

   // Number of decimal digit positions and the widths that follow from it
   localparam int ND    = 32;
   localparam int IDX_W = (ND > 1) ? $clog2(ND) : 1;
   localparam int CNT_W = $clog2(ND + 1);

   localparam logic [3:0] DIGIT_MAX = 4'd9;

   typedef logic [3:0] digit_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_CMP = 2'd2,
      OP_MUL = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      SGN_ZERO  = 2'd0,
      SGN_PLUS  = 2'd1,
      SGN_MINUS = 2'd2
   } sign_type;

   typedef enum logic [1:0] {
      CMP_LESS    = 2'd0,
      CMP_EQUAL   = 2'd1,
      CMP_GREATER = 2'd2
   } cmp_type;

   // Digit unit operations: x + mult*y + carry, x - y - borrow, constant zero
   typedef enum logic [1:0] {
      ALU_MAC  = 2'd0,
      ALU_SUB  = 2'd1,
      ALU_ZERO = 2'd2
   } alu_mode_type;

   typedef struct packed {
      alu_mode_type mode;
      digit_type    mult;
   } alu_cmd_type;

   typedef enum logic [3:0] {
      ST_LOAD    = 4'd0,
      ST_CMP     = 4'd1,
      ST_ADD     = 4'd2,
      ST_MUL_A   = 4'd3,
      ST_MUL_AW  = 4'd4,
      ST_ROW     = 4'd5,
      ST_NZ      = 4'd6,
      ST_EMIT_RD = 4'd7,
      ST_EMIT    = 4'd8
   } state_type;

   // Map a raw sign code; the unused code counts as zero
   function automatic sign_type decode_sign(input logic [1:0] code);
      sign_type s;
      priority if (code == SGN_PLUS)  s = SGN_PLUS;
      else if (code == SGN_MINUS)     s = SGN_MINUS;
      else                            s = SGN_ZERO;
      return s;
   endfunction

   function automatic sign_type negate_sign(input sign_type s);
      sign_type r;
      unique case (s)
         SGN_PLUS:  r = SGN_MINUS;
         SGN_MINUS: r = SGN_PLUS;
         default:   r = SGN_ZERO;
      endcase
      return r;
   endfunction

   // Order of the signs for the signed compare: minus < zero < plus
   function automatic logic [1:0] sign_rank(input sign_type s);
      logic [1:0] r;
      unique case (s)
         SGN_MINUS: r = 2'd0;
         SGN_PLUS:  r = 2'd2;
         default:   r = 2'd1;
      endcase
      return r;
   endfunction

   function automatic digit_type saturate_digit(input logic [3:0] d);
      return (d > DIGIT_MAX) ? DIGIT_MAX : d;
   endfunction

endpackage

// ----- hw/rtl/signed_decimal_add_sub_mul.sv -----
// Top level of the signed-magnitude decimal add/subtract/compare/multiply unit.
// Depends on sdasm_pkg, sdasm_digit_alu and signed_decimal_add_sub_mul_assert.svh.
//
//  channel  direction  ports                              carries
//  req      in         req_tvalid/tready/tdata/tuser/tlast  digit pair, signs, opcode
//  rsp      out        rsp_tvalid/tready/tdata/tlast        result digit and flags
//
// Loading takes one digit pair per cycle. After the last pair the sequencer runs
// the shared digit unit over the digit memories: a compare pass, then an
// add/subtract pass or a multiply with a row pass for row 0 and for each further
// nonzero digit of a, a zero scan, and ND result transfers at one per cycle while
// rsp is not stalled. req_tready is high only while loading.
// Reset is synchronous; the digit memories are not cleared, the fill count masks
// positions that were not loaded. A stalled rsp holds the sequencer in place.
`include "signed_decimal_add_sub_mul_assert.svh"

module signed_decimal_add_sub_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // digit_a[3:0], digit_b[7:4], sign_a[9:8],
                                    // sign_b[11:10], zeros[15:12]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   input  logic        req_tlast,   // last_digit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result_digit[3:0], result_sign[5:4],
                                    // compare_result[7:6], overflow[8], zeros[15:9]
   output logic        rsp_tlast    // last_result
);

   localparam int ND    = sdasm_pkg::ND;
   localparam int IDX_W = sdasm_pkg::IDX_W;
   localparam int CNT_W = sdasm_pkg::CNT_W;

   // Sequencer and pass control
   sdasm_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]        load_pos_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    pipe_vld_ff;
   logic [IDX_W-1:0]        pipe_idx_ff;
   logic [IDX_W-1:0]        mul_i_ff;

   // Operation context
   sdasm_pkg::opcode_type   op_ff;
   sdasm_pkg::sign_type     sa_ff, sb_ff, rsign_ff;
   sdasm_pkg::cmp_type      mag_ff, cmpcode_ff;
   sdasm_pkg::alu_mode_type mode_ff;
   logic                    mag_done_ff, hb_found_ff, swap_ff, ovf_ff, nz_ff;
   logic [IDX_W-1:0]        hb_ff;
   logic [3:0]              carry_ff;
   sdasm_pkg::digit_type    mdig_ff;

   // Output register
   logic                    rsp_vld_ff, rsp_last_ff, rsp_ovf_ff;
   sdasm_pkg::digit_type    rsp_digit_ff;
   sdasm_pkg::sign_type     rsp_sign_ff;
   sdasm_pkg::cmp_type      rsp_cmp_ff;

   // Digit memories
   sdasm_pkg::digit_type    mem_a   [ND];
   sdasm_pkg::digit_type    mem_b   [ND];
   sdasm_pkg::digit_type    mem_acc [ND];
   sdasm_pkg::digit_type    q_a_ff, q_b_ff, q_acc_ff;

   // Combinational control
   logic                    req_xfer, out_free, issue, pass_done, mul_go, row_skip;
   logic [CNT_W-1:0]        limit;
   logic [IDX_W-1:0]        issue_idx, raddr_a, raddr_b, raddr_acc, acc_waddr;
   logic                    acc_we, in_range, a_in_range;
   sdasm_pkg::digit_type    x_eff, y_eff, a_dig, alu_x, alu_y, alu_digit;
   logic [3:0]              alu_carry;
   sdasm_pkg::alu_cmd_type  alu_cmd;
   sdasm_pkg::cmp_type      mag_nx, cmp_fin;
   sdasm_pkg::sign_type     sbe;
   logic                    hb_found_nx;
   logic [IDX_W-1:0]        hb_nx;
   logic [IDX_W:0]          hb_span;

   assign req_tready = (state_ff == sdasm_pkg::ST_LOAD);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'b0000000, rsp_ovf_ff, rsp_cmp_ff, rsp_sign_ff, rsp_digit_ff};

   // Operand digits as seen by the passes: zero beyond the fill count or for sign zero
   assign in_range   = CNT_W'(pipe_idx_ff) < load_pos_ff;
   assign a_in_range = CNT_W'(mul_i_ff) < load_pos_ff;
   assign x_eff = (sa_ff != sdasm_pkg::SGN_ZERO && in_range) ? q_a_ff : 4'd0;
   assign y_eff = (sb_ff != sdasm_pkg::SGN_ZERO && in_range) ? q_b_ff : 4'd0;
   assign a_dig = a_in_range ? q_a_ff : 4'd0;
   assign row_skip = (mul_i_ff != '0) && (a_dig == 4'd0);
   assign sbe = (op_ff == sdasm_pkg::OP_SUB) ? sdasm_pkg::negate_sign(sb_ff) : sb_ff;
   assign mul_go = (op_ff == sdasm_pkg::OP_MUL) && (sa_ff != sdasm_pkg::SGN_ZERO) &&
                   (sb_ff != sdasm_pkg::SGN_ZERO);
   assign hb_span = {1'b0, hb_ff} + {1'b0, mul_i_ff};

   // Magnitude compare and top nonzero digit of b, scanned from the top
   always_comb begin
      mag_nx      = mag_ff;
      hb_found_nx = hb_found_ff;
      hb_nx       = hb_ff;
      if (pipe_vld_ff && !mag_done_ff) begin
         if (x_eff > y_eff)      mag_nx = sdasm_pkg::CMP_GREATER;
         else if (x_eff < y_eff) mag_nx = sdasm_pkg::CMP_LESS;
      end
      if (pipe_vld_ff && !hb_found_ff && y_eff != 4'd0) begin
         hb_found_nx = 1'b1;
         hb_nx       = pipe_idx_ff;
      end
   end

   // Signed compare outcome from the signs and the magnitude order
   always_comb begin
      if (sdasm_pkg::sign_rank(sa_ff) != sdasm_pkg::sign_rank(sb_ff)) begin
         cmp_fin = (sdasm_pkg::sign_rank(sa_ff) > sdasm_pkg::sign_rank(sb_ff)) ?
                   sdasm_pkg::CMP_GREATER : sdasm_pkg::CMP_LESS;
      end else if (sa_ff == sdasm_pkg::SGN_ZERO) begin
         cmp_fin = sdasm_pkg::CMP_EQUAL;
      end else if (sa_ff == sdasm_pkg::SGN_PLUS || mag_nx == sdasm_pkg::CMP_EQUAL) begin
         cmp_fin = mag_nx;
      end else begin
         cmp_fin = (mag_nx == sdasm_pkg::CMP_GREATER) ? sdasm_pkg::CMP_LESS :
                   sdasm_pkg::CMP_GREATER;
      end
   end

   // Addresses, digit unit operands and pass completion per state
   always_comb begin
      limit        = CNT_W'(ND);
      issue        = 1'b0;
      issue_idx    = cnt_ff[IDX_W-1:0];
      raddr_a      = cnt_ff[IDX_W-1:0];
      raddr_b      = cnt_ff[IDX_W-1:0];
      raddr_acc    = cnt_ff[IDX_W-1:0];
      acc_we       = 1'b0;
      acc_waddr    = pipe_idx_ff;
      alu_cmd.mode = sdasm_pkg::ALU_ZERO;
      alu_cmd.mult = 4'd1;
      alu_x        = x_eff;
      alu_y        = y_eff;
      pass_done    = 1'b0;
      unique case (state_ff)
         sdasm_pkg::ST_CMP: begin
            issue     = cnt_ff < limit;
            issue_idx = IDX_W'(ND - 1) - cnt_ff[IDX_W-1:0];
            raddr_a   = issue_idx;
            raddr_b   = issue_idx;
            pass_done = pipe_vld_ff && (pipe_idx_ff == '0);
         end
         sdasm_pkg::ST_ADD: begin
            issue        = cnt_ff < limit;
            alu_cmd.mode = mode_ff;
            alu_x        = swap_ff ? y_eff : x_eff;
            alu_y        = swap_ff ? x_eff : y_eff;
            acc_we       = pipe_vld_ff;
            pass_done    = pipe_vld_ff && (pipe_idx_ff == IDX_W'(ND - 1));
         end
         sdasm_pkg::ST_MUL_A, sdasm_pkg::ST_MUL_AW: begin
            raddr_a = mul_i_ff;
         end
         sdasm_pkg::ST_ROW: begin
            limit        = CNT_W'(ND) - CNT_W'(mul_i_ff);
            issue        = cnt_ff < limit;
            raddr_acc    = mul_i_ff + cnt_ff[IDX_W-1:0];
            alu_cmd.mode = sdasm_pkg::ALU_MAC;
            alu_cmd.mult = mdig_ff;
            alu_x        = (mul_i_ff == '0) ? 4'd0 : q_acc_ff;
            acc_we       = pipe_vld_ff;
            acc_waddr    = mul_i_ff + pipe_idx_ff;
            pass_done    = pipe_vld_ff && (pipe_idx_ff == IDX_W'(ND - 1) - mul_i_ff);
         end
         sdasm_pkg::ST_NZ: begin
            issue     = cnt_ff < limit;
            pass_done = pipe_vld_ff && (pipe_idx_ff == IDX_W'(ND - 1));
         end
         sdasm_pkg::ST_EMIT: begin
            raddr_acc = out_free ? cnt_ff[IDX_W-1:0] + 1'b1 : cnt_ff[IDX_W-1:0];
         end
         default: ;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sdasm_pkg::ST_LOAD: begin
            if (req_xfer && req_tlast) state_in = sdasm_pkg::ST_CMP;
         end
         sdasm_pkg::ST_CMP: begin
            if (pass_done) state_in = mul_go ? sdasm_pkg::ST_MUL_A : sdasm_pkg::ST_ADD;
         end
         sdasm_pkg::ST_ADD: begin
            if (pass_done) state_in = sdasm_pkg::ST_NZ;
         end
         sdasm_pkg::ST_MUL_A: state_in = sdasm_pkg::ST_MUL_AW;
         sdasm_pkg::ST_MUL_AW: begin
            if (!row_skip)                          state_in = sdasm_pkg::ST_ROW;
            else if (mul_i_ff == IDX_W'(ND - 1))    state_in = sdasm_pkg::ST_NZ;
            else                                    state_in = sdasm_pkg::ST_MUL_A;
         end
         sdasm_pkg::ST_ROW: begin
            if (pass_done) begin
               state_in = (mul_i_ff == IDX_W'(ND - 1)) ? sdasm_pkg::ST_NZ :
                          sdasm_pkg::ST_MUL_A;
            end
         end
         sdasm_pkg::ST_NZ: begin
            if (pass_done) state_in = sdasm_pkg::ST_EMIT_RD;
         end
         sdasm_pkg::ST_EMIT_RD: state_in = sdasm_pkg::ST_EMIT;
         sdasm_pkg::ST_EMIT: begin
            if (out_free && cnt_ff == CNT_W'(ND - 1)) state_in = sdasm_pkg::ST_LOAD;
         end
         default: state_in = sdasm_pkg::ST_LOAD;
      endcase
   end

   sdasm_digit_alu u_alu (
      .cmd       (alu_cmd),
      .x         (alu_x),
      .y         (alu_y),
      .carry_in  (carry_ff),
      .digit_out (alu_digit),
      .carry_out (alu_carry)
   );

   // Operand memories: written while loading, read by the passes
   always_ff @(posedge clock) begin
      if (req_xfer && load_pos_ff < CNT_W'(ND)) begin
         mem_a[load_pos_ff[IDX_W-1:0]] <= sdasm_pkg::saturate_digit(req_tdata[3:0]);
         mem_b[load_pos_ff[IDX_W-1:0]] <= sdasm_pkg::saturate_digit(req_tdata[7:4]);
      end
      q_a_ff <= mem_a[raddr_a];
      q_b_ff <= mem_b[raddr_b];
   end

   // Accumulator memory: one write and one read a cycle
   always_ff @(posedge clock) begin
      if (acc_we) mem_acc[acc_waddr] <= alu_digit;
      q_acc_ff <= mem_acc[raddr_acc];
   end

   // Sequencer, pass bookkeeping and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= sdasm_pkg::ST_LOAD;
         load_pos_ff <= '0;
         cnt_ff      <= '0;
         pipe_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pipe_vld_ff <= issue;
         pipe_idx_ff <= issue_idx;

         // Restart the step count on every pass change
         if (state_in != state_ff) cnt_ff <= '0;
         else if (issue || (state_ff == sdasm_pkg::ST_EMIT && out_free))
            cnt_ff <= cnt_ff + 1'b1;

         // Take a digit pair; latch opcode and signs with the last one
         if (req_xfer) begin
            if (load_pos_ff < CNT_W'(ND)) load_pos_ff <= load_pos_ff + 1'b1;
            if (req_tlast) begin
               op_ff       <= sdasm_pkg::opcode_type'(req_tuser);
               sa_ff       <= sdasm_pkg::decode_sign(req_tdata[9:8]);
               sb_ff       <= sdasm_pkg::decode_sign(req_tdata[11:10]);
               mag_ff      <= sdasm_pkg::CMP_EQUAL;
               mag_done_ff <= 1'b0;
               hb_found_ff <= 1'b0;
            end
         end

         // Compare pass: settle the operation mode and result sign at its end
         if (state_ff == sdasm_pkg::ST_CMP) begin
            mag_ff      <= mag_nx;
            mag_done_ff <= mag_done_ff || (mag_nx != sdasm_pkg::CMP_EQUAL);
            hb_found_ff <= hb_found_nx;
            hb_ff       <= hb_nx;
            if (pass_done) begin
               cmpcode_ff <= cmp_fin;
               carry_ff   <= 4'd0;
               ovf_ff     <= 1'b0;
               nz_ff      <= 1'b0;
               mul_i_ff   <= '0;
               swap_ff    <= 1'b0;
               if (op_ff == sdasm_pkg::OP_CMP || (op_ff == sdasm_pkg::OP_MUL && !mul_go)) begin
                  mode_ff  <= sdasm_pkg::ALU_ZERO;
                  rsign_ff <= sdasm_pkg::SGN_ZERO;
               end else if (op_ff == sdasm_pkg::OP_MUL) begin
                  mode_ff  <= sdasm_pkg::ALU_MAC;
                  rsign_ff <= (sa_ff == sb_ff) ? sdasm_pkg::SGN_PLUS : sdasm_pkg::SGN_MINUS;
               end else if (sa_ff == sdasm_pkg::SGN_ZERO) begin
                  mode_ff  <= sdasm_pkg::ALU_MAC;
                  rsign_ff <= sbe;
               end else if (sbe == sdasm_pkg::SGN_ZERO || sa_ff == sbe) begin
                  mode_ff  <= sdasm_pkg::ALU_MAC;
                  rsign_ff <= sa_ff;
               end else begin
                  mode_ff  <= sdasm_pkg::ALU_SUB;
                  swap_ff  <= (mag_nx == sdasm_pkg::CMP_LESS);
                  priority case (mag_nx)
                     sdasm_pkg::CMP_GREATER: rsign_ff <= sa_ff;
                     sdasm_pkg::CMP_LESS:    rsign_ff <= sbe;
                     default:                rsign_ff <= sdasm_pkg::SGN_ZERO;
                  endcase
               end
            end
         end

         // Add or subtract pass: ripple the carry, flag a carry out of the top
         if (state_ff == sdasm_pkg::ST_ADD && pipe_vld_ff) begin
            carry_ff <= alu_carry;
            if (pass_done && mode_ff == sdasm_pkg::ALU_MAC && alu_carry != 4'd0)
               ovf_ff <= 1'b1;
         end

         // Multiply: pick up the digit of a for this row, flag a row that reaches past the top, skip a zero row
         if (state_ff == sdasm_pkg::ST_MUL_AW) begin
            mdig_ff  <= a_dig;
            carry_ff <= 4'd0;
            if (a_dig != 4'd0 && hb_found_ff && hb_span >= (IDX_W + 1)'(ND)) ovf_ff <= 1'b1;
            if (row_skip && mul_i_ff != IDX_W'(ND - 1)) mul_i_ff <= mul_i_ff + 1'b1;
         end

         // Multiply row: accumulate, drop what falls past the top digit
         if (state_ff == sdasm_pkg::ST_ROW && pipe_vld_ff) begin
            carry_ff <= alu_carry;
            if (pass_done) begin
               if (alu_carry != 4'd0) ovf_ff <= 1'b1;
               if (mul_i_ff != IDX_W'(ND - 1)) mul_i_ff <= mul_i_ff + 1'b1;
            end
         end

         // Zero scan of the result
         if (state_ff == sdasm_pkg::ST_NZ && pipe_vld_ff && q_acc_ff != 4'd0) nz_ff <= 1'b1;

         // Result transfers; the operands are released after the top digit
         if (state_ff == sdasm_pkg::ST_EMIT && out_free) begin
            rsp_vld_ff   <= 1'b1;
            rsp_digit_ff <= q_acc_ff;
            rsp_sign_ff  <= nz_ff ? rsign_ff : sdasm_pkg::SGN_ZERO;
            rsp_cmp_ff   <= cmpcode_ff;
            rsp_ovf_ff   <= ovf_ff;
            rsp_last_ff  <= (cnt_ff == CNT_W'(ND - 1));
            if (cnt_ff == CNT_W'(ND - 1)) load_pos_ff <= '0;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Accumulator writes of a multiply row stay inside the digit range
   `SDASM_ASSERT_IMPL(a_row_in_range, clock, reset, state_ff == sdasm_pkg::ST_ROW && pipe_vld_ff, ({1'b0, mul_i_ff} + {1'b0, pipe_idx_ff}) < (IDX_W + 1)'(ND))
   // A digit in flight was issued in the same pass that consumes it
   `SDASM_ASSERT_IMPL(a_pipe_same_pass, clock, reset, pipe_vld_ff, state_ff == $past(state_ff))
   // While digits remain to be sent, the sequencer stays in the emit state
   `SDASM_ASSERT_IMPL(a_emit_holds, clock, reset, rsp_vld_ff && rsp_tready && !rsp_last_ff, state_ff == sdasm_pkg::ST_EMIT)
   // Loading never runs while a result is being produced
   `SDASM_ASSERT_NEXT(a_no_load_in_op, clock, reset, req_xfer && req_tlast, !req_tready)

endmodule

// ----- hw/rtl/sdasm_digit_alu.sv -----
// Shared one-digit decimal unit: multiply-accumulate with carry, subtract
// with borrow, or zero. Depends on sdasm_pkg.
module sdasm_digit_alu (
   input  sdasm_pkg::alu_cmd_type cmd,
   input  sdasm_pkg::digit_type   x,
   input  sdasm_pkg::digit_type   y,
   input  logic [3:0]             carry_in,
   output sdasm_pkg::digit_type   digit_out,
   output logic [3:0]             carry_out
);

   logic [6:0] prod;
   logic [6:0] sum;
   logic [3:0] quot;
   logic [6:0] rem;
   logic [4:0] diff;

   // Sum stays below 100: quotient by ten from nine parallel thresholds
   always_comb begin
      prod = {3'b000, cmd.mult} * {3'b000, y};
      sum  = {3'b000, x} + prod + {3'b000, carry_in};
      quot = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (sum >= 7'(10 * k)) quot = 4'(k);
      end
      rem  = sum - ({3'b000, quot} * 7'd10);
      diff = {1'b0, x} - {1'b0, y} - {4'b0000, carry_in[0]};
   end

   // Select the operation result
   always_comb begin
      unique case (cmd.mode)
         sdasm_pkg::ALU_MAC: begin
            digit_out = rem[3:0];
            carry_out = quot;
         end
         sdasm_pkg::ALU_SUB: begin
            if (diff[4]) begin
               digit_out = 4'(diff + 5'd10);
               carry_out = 4'd1;
            end else begin
               digit_out = diff[3:0];
               carry_out = 4'd0;
            end
         end
         default: begin
            digit_out = 4'd0;
            carry_out = 4'd0;
         end
      endcase
   end

endmodule
